FILE: sv/trpd_pkg.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder package
// Shared constants for the packet decoder and its register file.
// ----------------------------------------------------------------------------
`default_nettype none

package trpd_pkg;

   // Header bytes below this value start a raw packet.
   localparam logic [7:0] RAW_LIMIT = 8'd128;
   // A repeat packet header minus this value gives the run length.
   localparam logic [7:0] RUN_BIAS  = 8'd127;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register byte addresses.
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_IMAGE_WIDTH  = 4'h0;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_IMAGE_HEIGHT = 4'h4;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_HAS_ALPHA    = 4'h8;

   // Index of the last byte of a pixel for each pixel format.
   localparam logic [1:0] LAST_BYTE_RGB  = 2'd2;
   localparam logic [1:0] LAST_BYTE_RGBA = 2'd3;

   localparam int unsigned RSP_DATA_WIDTH = 40;

endpackage

`default_nettype wire

FILE: sv/tga_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Decodes the packet bytes of a run-length compressed TGA image, one byte
// per transaction, into R,G,B,A pixels with repeat counts.
// ----------------------------------------------------------------------------
// A result is registered and presented on rsp in the cycle after the byte that
// completes a pixel is accepted. Throughput: one byte per clock cycle while rsp
// is not stalled, as set by the single output register with a pass-through ready.
// Reset clears the decode state and loads width 1, height 1, 24-bit pixels;
// the block accepts bytes from the first cycle after reset.
`default_nettype none

module tga_rle_pixel_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  wire logic [0:0]  req_tuser,   // [0] frame_start
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [trpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // rsp_tdata: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
   //            [39:32] repeat_count
   output logic             rsp_tlast,   // image_done
   output logic [0:0]       rsp_tuser,   // [0] overrun_error
   // Configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [trpd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [trpd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [trpd_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers and the pixel total derived from them.
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic        has_alpha_ff;
   logic [31:0] pixel_total_ff;

   logic        csr_write;
   logic        wr_width;
   logic        wr_height;
   logic        wr_alpha;
   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] pixel_total_in;

   // Decode state.
   logic        in_pixel_bytes_ff,   in_pixel_bytes_in;
   logic        packet_is_repeat_ff, packet_is_repeat_in;
   logic [7:0]  pixels_left_ff,      pixels_left_in;
   logic [1:0]  byte_in_pixel_ff,    byte_in_pixel_in;
   logic [23:0] byte_store_ff,       byte_store_in;
   logic [31:0] pixels_decoded_ff,   pixels_decoded_in;
   logic        image_finished_ff,   image_finished_in;
   logic        error_latched_ff,    error_latched_in;

   // Result register.
   logic        rsp_valid_ff,  rsp_valid_in;
   logic [7:0]  red_ff,        red_in;
   logic [7:0]  green_ff,      green_in;
   logic [7:0]  blue_ff,       blue_in;
   logic [7:0]  alpha_ff,      alpha_in;
   logic [7:0]  count_ff,      count_in;
   logic        done_ff,       done_in;
   logic        overrun_ff,    overrun_in;

   logic        accept;
   logic        emit;
   logic [7:0]  stream_byte;
   logic        frame_start;
   logic [1:0]  last_index;
   logic        in_pixel_eff;
   logic [31:0] decoded_eff;
   logic        halted;
   logic [7:0]  pixel_count;
   logic [32:0] after_sum;
   logic        overrun;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_width   = csr_write && (csr_paddr == trpd_pkg::ADDR_IMAGE_WIDTH);
   assign wr_height  = csr_write && (csr_paddr == trpd_pkg::ADDR_IMAGE_HEIGHT);
   assign wr_alpha   = csr_write && (csr_paddr == trpd_pkg::ADDR_HAS_ALPHA);

   // The total is refreshed together with the register write, so it is
   // already valid for the first byte after the write.
   assign mul_a          = wr_width  ? csr_pwdata[15:0] : image_width_ff;
   assign mul_b          = wr_height ? csr_pwdata[15:0] : image_height_ff;
   assign pixel_total_in = 32'(mul_a) * 32'(mul_b);

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr)
         trpd_pkg::ADDR_IMAGE_WIDTH:  csr_prdata[15:0] = image_width_ff;
         trpd_pkg::ADDR_IMAGE_HEIGHT: csr_prdata[15:0] = image_height_ff;
         trpd_pkg::ADDR_HAS_ALPHA:    csr_prdata[0]    = has_alpha_ff;
         default:                     csr_prdata       = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 16'd1;
         image_height_ff <= 16'd1;
         has_alpha_ff    <= 1'b0;
         pixel_total_ff  <= 32'd1;
      end else begin
         if (wr_width) begin
            image_width_ff <= csr_pwdata[15:0];
         end
         if (wr_height) begin
            image_height_ff <= csr_pwdata[15:0];
         end
         if (wr_alpha) begin
            has_alpha_ff <= csr_pwdata[0];
         end
         if (wr_width || wr_height) begin
            pixel_total_ff <= pixel_total_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign stream_byte = req_tdata;
   assign frame_start = req_tuser[0];

   // ------------------------------------------------------------------------
   // Packet decode
   // ------------------------------------------------------------------------
   assign last_index   = has_alpha_ff ? trpd_pkg::LAST_BYTE_RGBA : trpd_pkg::LAST_BYTE_RGB;
   // A frame start clears the image before the byte is looked at.
   assign in_pixel_eff = frame_start ? 1'b0  : in_pixel_bytes_ff;
   assign decoded_eff  = frame_start ? 32'd0 : pixels_decoded_ff;
   assign halted       = !frame_start && (image_finished_ff || error_latched_ff);
   assign pixel_count  = packet_is_repeat_ff ? pixels_left_ff : 8'd1;
   assign after_sum    = {1'b0, decoded_eff} + 33'(pixel_count);
   assign overrun      = after_sum > {1'b0, pixel_total_ff};

   always_comb begin
      in_pixel_bytes_in   = in_pixel_eff;
      packet_is_repeat_in = packet_is_repeat_ff;
      pixels_left_in      = pixels_left_ff;
      byte_in_pixel_in    = byte_in_pixel_ff;
      byte_store_in       = byte_store_ff;
      pixels_decoded_in   = decoded_eff;
      image_finished_in   = frame_start ? 1'b0 : image_finished_ff;
      error_latched_in    = frame_start ? 1'b0 : error_latched_ff;
      emit                = 1'b0;
      red_in              = '0;
      green_in            = '0;
      blue_in             = '0;
      alpha_in            = '0;
      count_in            = '0;
      done_in             = 1'b0;
      overrun_in          = 1'b0;

      if (halted) begin
         // Bytes after the end of an image or after an overrun are dropped until the next frame.
      end else if (!in_pixel_eff) begin
         if (stream_byte < trpd_pkg::RAW_LIMIT) begin
            packet_is_repeat_in = 1'b0;
            pixels_left_in      = stream_byte + 8'd1;
         end else begin
            packet_is_repeat_in = 1'b1;
            pixels_left_in      = stream_byte - trpd_pkg::RUN_BIAS;
         end
         in_pixel_bytes_in = 1'b1;
         byte_in_pixel_in  = 2'd0;
         byte_store_in     = '0;
      end else if (byte_in_pixel_ff < last_index) begin
         case (byte_in_pixel_ff)
            2'd0:    byte_store_in[7:0]   = stream_byte;
            2'd1:    byte_store_in[15:8]  = stream_byte;
            2'd2:    byte_store_in[23:16] = stream_byte;
            default: byte_store_in        = byte_store_ff;
         endcase
         byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
      end else begin
         emit             = 1'b1;
         byte_in_pixel_in = 2'd0;
         byte_store_in    = '0;
         if (overrun) begin
            overrun_in        = 1'b1;
            error_latched_in  = 1'b1;
            in_pixel_bytes_in = 1'b0;
            pixels_left_in    = '0;
         end else begin
            blue_in  = byte_store_ff[7:0];
            green_in = byte_store_ff[15:8];
            if (has_alpha_ff) begin
               red_in   = byte_store_ff[23:16];
               alpha_in = stream_byte;
            end else begin
               red_in   = stream_byte;
               alpha_in = '0;
            end
            count_in          = pixel_count;
            pixels_decoded_in = after_sum[31:0];
            if (packet_is_repeat_ff || pixels_left_ff <= 8'd1) begin
               pixels_left_in    = '0;
               in_pixel_bytes_in = 1'b0;
               if (after_sum[31:0] == pixel_total_ff) begin
                  image_finished_in = 1'b1;
                  done_in           = 1'b1;
               end
            end else begin
               pixels_left_in = pixels_left_ff - 8'd1;
            end
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pixel_bytes_ff   <= 1'b0;
         packet_is_repeat_ff <= 1'b0;
         pixels_left_ff      <= '0;
         byte_in_pixel_ff    <= '0;
         byte_store_ff       <= '0;
         pixels_decoded_ff   <= '0;
         image_finished_ff   <= 1'b0;
         error_latched_ff    <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_pixel_bytes_ff   <= in_pixel_bytes_in;
            packet_is_repeat_ff <= packet_is_repeat_in;
            pixels_left_ff      <= pixels_left_in;
            byte_in_pixel_ff    <= byte_in_pixel_in;
            byte_store_ff       <= byte_store_in;
            pixels_decoded_ff   <= pixels_decoded_in;
            image_finished_ff   <= image_finished_in;
            error_latched_ff    <= error_latched_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         alpha_ff   <= alpha_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
         overrun_ff <= overrun_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {count_ff, alpha_ff, blue_ff, green_ff, red_ff};
   assign rsp_tlast    = done_ff;
   assign rsp_tuser[0] = overrun_ff;

endmodule

`default_nettype wire
